@@ hdl/ghcg_pkg.sv @@
// ghcg_pkg: widths, register codes, shared types and the division step for the
// grid hypercube corner generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ghcg_pkg;

   localparam int IDX_W          = 30;
   localparam int PTS_W          = 11;
   localparam int DIMS_W         = 2;
   localparam int CORNER_W       = 3;
   localparam int NUM_AXES       = 3;
   localparam int CSR_IDX_W      = 2;
   localparam int BITS_PER_STAGE = 2;
   localparam int NUM_STAGES     = IDX_W / BITS_PER_STAGE;
   localparam int STRIDE0_W      = 2 * PTS_W;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd2;
   localparam logic [PTS_W-1:0]  PTS_RESET  = 11'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_DIMS    = 2'd0,
      CSR_POINTS_DIM0 = 2'd1,
      CSR_POINTS_DIM1 = 2'd2,
      CSR_POINTS_DIM2 = 2'd3
   } csr_addr_type;

   typedef logic [PTS_W-1:0] pts_type;
   typedef pts_type [NUM_AXES-1:0] axis_vec_type;

   // dims is the clamped count; divisor is the point count of a used axis, else one
   typedef struct packed {
      logic [DIMS_W-1:0]    dims;
      axis_vec_type         points;
      axis_vec_type         divisor;
      logic [STRIDE0_W-1:0] stride0;
   } cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0]  node;
      logic [DIMS_W-1:0] dims;
   } item_type;

   // one dividend bit through the chained dividers, fastest axis first;
   // each quotient bit feeds the next slower divider
   function automatic axis_vec_type div_bit(axis_vec_type r, logic b, axis_vec_type d);
      axis_vec_type   n;
      logic           carry;
      logic [PTS_W:0] t;
      n     = r;
      carry = b;
      for (int k = NUM_AXES - 1; k >= 0; k--) begin
         t = {r[k], carry};
         if (t >= {1'b0, d[k]}) begin
            n[k]  = PTS_W'(t - {1'b0, d[k]});
            carry = 1'b1;
         end else begin
            n[k]  = t[PTS_W-1:0];
            carry = 1'b0;
         end
      end
      return n;
   endfunction

   // node starts an element only if every used coordinate is below its last point
   function automatic logic keep_node(axis_vec_type r, cfg_type c);
      logic ok;
      ok = 1'b1;
      for (int k = 0; k < NUM_AXES; k++) begin
         if (k < int'(c.dims)) begin
            if (c.points[k] < PTS_W'(2) || r[k] >= PTS_W'(c.points[k] - PTS_W'(1))) begin
               ok = 1'b0;
            end
         end
      end
      return ok;
   endfunction

   function automatic logic [CORNER_W-1:0] corner_max(logic [DIMS_W-1:0] dims);
      logic [CORNER_W-1:0] m;
      case (dims)
         2'd1: begin
            m = 3'd1;
         end
         2'd2: begin
            m = 3'd3;
         end
         default: begin
            m = 3'd7;
         end
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

@@ hdl/grid_hypercube_corner_generator_unit.sv @@
// grid_hypercube_corner_generator_unit: top level with control registers,
// front divider pipeline, element queue and corner walker. Uses ghcg_pkg.
//
//  channel   ports                               handshake
//  ------    ---------------------------------   --------------------------
//  csr       csr_write_en csr_index csr_data      write on enable, no wait
//  req       req_node_index                      push & !full
//  rsp       rsp_corner_index/number/last_corner  pop & !empty
//
// a node passes through the divider pipeline (2 index bits per stage) and
// the queue before its first corner shows; one node enters per cycle while
// req_full is low. the corner walker gives one corner per cycle while
// rsp_pop is high; an element gives 2, 4 or 8 corners, a rejected node none.
// reset: synchronous, clears control state and loads register defaults.
// req_full rises only while the queue is full and an element waits to enter it.
`timescale 1ns / 1ps
`default_nettype none
module grid_hypercube_corner_generator_unit #(
   parameter int MAX_DIMS = 3
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_write_en,
   input  wire [ghcg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [ghcg_pkg::PTS_W-1:0]      csr_data,
   input  wire                            req_push,
   output logic                           req_full,
   input  wire [ghcg_pkg::IDX_W-1:0]      req_node_index,
   output logic                           rsp_empty,
   input  wire                            rsp_pop,
   output logic [ghcg_pkg::IDX_W-1:0]     rsp_corner_index,
   output logic [ghcg_pkg::CORNER_W-1:0]  rsp_corner_number,
   output logic                           rsp_last_corner
);
   import ghcg_pkg::*;

   logic [DIMS_W-1:0]    num_dims_ff;
   logic [DIMS_W-1:0]    num_dims_in;
   axis_vec_type         points_ff;
   axis_vec_type         points_in;
   logic [STRIDE0_W-1:0] stride0_ff;
   logic [STRIDE0_W-1:0] stride0_in;
   logic [DIMS_W-1:0]    dims_eff;
   axis_vec_type         divisor;
   cfg_type              cfg;
   logic                 q_push;
   item_type             q_item;
   logic                 q_full;
   logic                 q_pop;
   item_type             q_head;
   logic                 q_empty;

   always_comb begin
      num_dims_in = num_dims_ff;
      points_in   = points_ff;
      if (csr_write_en) begin
         case (csr_addr_type'(csr_index))
            CSR_NUM_DIMS: begin
               num_dims_in = csr_data[DIMS_W-1:0];
            end
            CSR_POINTS_DIM0: begin
               points_in[0] = csr_data;
            end
            CSR_POINTS_DIM1: begin
               points_in[1] = csr_data;
            end
            CSR_POINTS_DIM2: begin
               points_in[2] = csr_data;
            end
            default: begin
               num_dims_in = num_dims_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= DIMS_RESET;
         points_ff   <= {NUM_AXES{PTS_RESET}};
      end else begin
         num_dims_ff <= num_dims_in;
         points_ff   <= points_in;
      end
   end

   // zero dims act as one, more than the maximum act as the maximum
   always_comb begin
      dims_eff = num_dims_ff;
      if (num_dims_ff == '0) begin
         dims_eff = DIMS_W'(1);
      end else if (int'(num_dims_ff) > MAX_DIMS) begin
         dims_eff = DIMS_W'(MAX_DIMS);
      end
      for (int k = 0; k < NUM_AXES; k++) begin
         divisor[k] = (k < int'(dims_eff)) ? points_ff[k] : PTS_W'(1);
      end
   end

   assign stride0_in = STRIDE0_W'(divisor[2] * divisor[1]);

   always_ff @(posedge clock) begin
      stride0_ff <= stride0_in;
   end

   assign cfg.dims    = dims_eff;
   assign cfg.points  = points_ff;
   assign cfg.divisor = divisor;
   assign cfg.stride0 = stride0_ff;

   ghcg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_node_index (req_node_index),
      .queue_full     (q_full),
      .queue_push     (q_push),
      .queue_item     (q_item)
   );

   ghcg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   ghcg_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .queue_empty       (q_empty),
      .queue_head        (q_head),
      .queue_pop         (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_corner_index  (rsp_corner_index),
      .rsp_corner_number (rsp_corner_number),
      .rsp_last_corner   (rsp_last_corner)
   );

   a_full_only_on_queue: assert property (@(posedge clock) disable iff (reset)
      req_full |-> q_full)
      else $error("req_full without a full queue");

   a_last_is_max: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last_corner) |->
      (rsp_corner_number == 3'd1 || rsp_corner_number == 3'd3 || rsp_corner_number == 3'd7))
      else $error("last corner flagged on a corner that is not final");

   a_corner_steps: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last_corner) |=>
      (!rsp_empty && rsp_corner_number == CORNER_W'($past(rsp_corner_number) + 1'b1)))
      else $error("corner sequence broken inside an element");

   a_element_restarts: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_last_corner) |=>
      (rsp_empty || rsp_corner_number == '0))
      else $error("new element does not start at corner zero");

endmodule
`default_nettype wire

@@ hdl/ghcg_front.sv @@
// ghcg_front: pipelined digit divider that splits the node index into
// coordinates and drops nodes that start no element. Uses ghcg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ghcg_front (
   input  wire                           clock,
   input  wire                           reset,
   input  ghcg_pkg::cfg_type             cfg,
   input  wire                           req_push,
   output logic                          req_full,
   input  wire [ghcg_pkg::IDX_W-1:0]     req_node_index,
   input  wire                           queue_full,
   output logic                          queue_push,
   output ghcg_pkg::item_type            queue_item
);
   import ghcg_pkg::*;

   localparam int LAST = NUM_STAGES - 1;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [IDX_W-1:0]      node_ff [NUM_STAGES];
   logic [IDX_W-1:0]      node_in [NUM_STAGES];
   axis_vec_type          rem_ff  [NUM_STAGES];
   axis_vec_type          rem_in  [NUM_STAGES];
   logic                  keep_last;
   logic                  advance;

   assign keep_last = keep_node(rem_ff[LAST], cfg);
   assign advance   = !(valid_ff[LAST] && keep_last && queue_full);
   assign req_full  = !advance;

   genvar s;
   generate
      for (s = 0; s < NUM_STAGES; s++) begin : g_stage
         logic [IDX_W-1:0] src_node;
         axis_vec_type     src_rem;
         logic             src_valid;

         if (s == 0) begin : g_first
            assign src_node  = req_node_index;
            assign src_rem   = '0;
            assign src_valid = req_push;
         end else begin : g_next
            assign src_node  = node_ff[s-1];
            assign src_rem   = rem_ff[s-1];
            assign src_valid = valid_ff[s-1];
         end

         always_comb begin : c_digit
            axis_vec_type r;
            r = src_rem;
            for (int j = 0; j < BITS_PER_STAGE; j++) begin
               r = div_bit(r, src_node[IDX_W - 1 - s * BITS_PER_STAGE - j], cfg.divisor);
            end
            rem_in[s]   = r;
            node_in[s]  = src_node;
            valid_in[s] = src_valid;
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               node_ff[s] <= node_in[s];
               rem_ff[s]  <= rem_in[s];
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   assign queue_push      = valid_ff[LAST] && keep_last && !queue_full;
   assign queue_item.node = node_ff[LAST];
   assign queue_item.dims = cfg.dims;

endmodule
`default_nettype wire

@@ hdl/ghcg_queue.sv @@
// ghcg_queue: short flop queue of accepted elements between front and back.
// Uses ghcg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ghcg_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  ghcg_pkg::item_type   push_item,
   output logic                 full,
   input  wire                  pop,
   output ghcg_pkg::item_type   head,
   output logic                 empty
);
   import ghcg_pkg::*;

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = QCNT_W'(count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

@@ hdl/ghcg_back.sv @@
// ghcg_back: walks the corners of one element per queue entry, one corner per
// transfer. Uses ghcg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ghcg_back (
   input  wire                            clock,
   input  wire                            reset,
   input  ghcg_pkg::cfg_type              cfg,
   input  wire                            queue_empty,
   input  ghcg_pkg::item_type             queue_head,
   output logic                           queue_pop,
   output logic                           rsp_empty,
   input  wire                            rsp_pop,
   output logic [ghcg_pkg::IDX_W-1:0]     rsp_corner_index,
   output logic [ghcg_pkg::CORNER_W-1:0]  rsp_corner_number,
   output logic                           rsp_last_corner
);
   import ghcg_pkg::*;

   logic                cur_valid_ff;
   logic                cur_valid_in;
   item_type            cur_item_ff;
   item_type            cur_item_in;
   logic [CORNER_W-1:0] corner_ff;
   logic [CORNER_W-1:0] corner_in;
   logic                fire;
   logic                last;
   logic [IDX_W-1:0]    off0;
   logic [IDX_W-1:0]    off1;

   assign fire      = cur_valid_ff && rsp_pop;
   assign last      = (corner_ff == corner_max(cur_item_ff.dims));
   assign queue_pop = (!cur_valid_ff || (fire && last)) && !queue_empty;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_item_in  = cur_item_ff;
      corner_in    = corner_ff;
      if (queue_pop) begin
         cur_valid_in = 1'b1;
         cur_item_in  = queue_head;
         corner_in    = '0;
      end else if (fire && last) begin
         cur_valid_in = 1'b0;
      end else if (fire) begin
         corner_in = CORNER_W'(corner_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         corner_ff    <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         corner_ff    <= corner_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_item_ff <= cur_item_in;
   end

   // strides: axis 0 is stride0, axis 1 is the axis-2 divisor, axis 2 is one
   assign off0 = corner_ff[0] ? IDX_W'(cfg.stride0) : '0;
   assign off1 = corner_ff[1] ? IDX_W'(cfg.divisor[2]) : '0;

   assign rsp_empty         = !cur_valid_ff;
   assign rsp_corner_number = corner_ff;
   assign rsp_last_corner   = last;
   assign rsp_corner_index  = IDX_W'(cur_item_ff.node + off0 + off1 + IDX_W'(corner_ff[2]));

endmodule
`default_nettype wire
